[sv/zrd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the zero-run decompressor.
// Used by the controller, the datapath and the top level.
package zrd_pkg;

  localparam int CNT_W  = 24;   // width of the per-stream byte counter
  localparam int BYTE_W = 8;
  localparam int ST_W   = 2;
  localparam int ZC_W   = 7;    // zero count per item, up to 64
  localparam int ZA_W   = 4;    // zeros owed after literals, up to 8

  localparam logic [ST_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [ST_W-1:0] STATUS_OVER  = 2'd1;
  localparam logic [ST_W-1:0] STATUS_TRUNC = 2'd2;

  localparam logic [CNT_W-1:0] CAP_RESET = '1;

  typedef enum logic [0:0] {
    CTL_IDLE,
    CTL_RUN
  } ctl_state_t;

  typedef struct packed {
    logic accept;    // take the input item and load its first result, if it has one
    logic advance;   // load the next pending result
  } ctl_cmd_t;

  typedef struct packed {
    logic out_valid;  // output register holds a result
    logic plan_more;  // input item on the port causes more than one result
    logic rem_more;   // results remain after the next advance
  } dp_status_t;

endpackage

[sv/zrd_ctrl.sv]
`timescale 1ns / 1ps
// Controller for the zero-run decompressor: accepts items and sequences
// multi-result runs. Depends on zrd_pkg.
module zrd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_ready,
  input  zrd_pkg::dp_status_t stat,
  output logic                in_ready,
  output zrd_pkg::ctl_cmd_t   cmd
);
  import zrd_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;
  logic       out_free;

  assign out_free = !stat.out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      CTL_IDLE: begin
        if (in_valid && out_free && stat.plan_more) begin
          state_next = CTL_RUN;
        end
      end
      CTL_RUN: begin
        if (out_free && !stat.rem_more) begin
          state_next = CTL_IDLE;
        end
      end
      default: state_next = CTL_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.accept  = 1'b0;
    cmd.advance = 1'b0;
    unique case (state)
      CTL_IDLE: begin
        in_ready   = out_free;
        cmd.accept = in_valid && out_free;
      end
      CTL_RUN: begin
        cmd.advance = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[sv/zrd_datapath.sv]
`timescale 1ns / 1ps
// Datapath for the zero-run decompressor: opcode decode, capacity check,
// stream state, pending-result counters and the output register. Uses zrd_pkg.
module zrd_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  zrd_pkg::ctl_cmd_t             cmd,
  output zrd_pkg::dp_status_t           stat,
  input  logic [zrd_pkg::BYTE_W-1:0]    in_byte,
  input  logic                          in_last,
  input  logic                          cfg_write_en,
  input  logic [zrd_pkg::CNT_W-1:0]     cfg_write_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [zrd_pkg::BYTE_W-1:0]    out_byte,
  output logic                          has_byte,
  output logic                          run_last,
  output logic                          stream_end,
  output logic [zrd_pkg::ST_W-1:0]      status,
  output logic [zrd_pkg::CNT_W-1:0]     total_length
);
  import zrd_pkg::*;

  // configuration and stream state
  logic [CNT_W-1:0]  capacity;
  logic              expect_lit;
  logic [BYTE_W-1:0] lit_left;
  logic [ZA_W-1:0]   zeros_after;
  logic [CNT_W-1:0]  bytes_written;
  logic [ST_W-1:0]   err_code;

  // pending results of the current item
  logic [ZC_W-1:0]   rem_zeros;
  logic              rem_stat;
  logic              end_flag;
  logic [ST_W-1:0]   end_status;
  logic [CNT_W-1:0]  end_total;

  // decode
  logic [BYTE_W-1:0] fit_run;
  logic [ZA_W-1:0]   mix_lits;
  logic [ZA_W-1:0]   mix_zeros;
  logic [CNT_W:0]    fit_sum;
  logic              fit_ok;

  logic              expect_lit_next;
  logic [BYTE_W-1:0] lit_left_next;
  logic [ZA_W-1:0]   zeros_after_next;
  logic [CNT_W-1:0]  bytes_written_next;
  logic [ST_W-1:0]   err_code_next;
  logic [BYTE_W-1:0] delta;
  logic              plan_lit;
  logic [ZC_W-1:0]   plan_zeros;
  logic              plan_stat;
  logic [ST_W-1:0]   plan_status;
  logic [CNT_W-1:0]  plan_total;
  logic              plan_any;

  // selection of the result to load
  logic              load;
  logic [BYTE_W-1:0] ld_byte;
  logic              ld_has;
  logic [ZC_W-1:0]   ld_rem_zeros;
  logic              ld_rem_stat;
  logic              ld_last;
  logic              ld_end;
  logic [ST_W-1:0]   ld_status;
  logic [CNT_W-1:0]  ld_total;

  assign mix_lits  = {1'b0, in_byte[5:3]} + ZA_W'(1);
  assign mix_zeros = {1'b0, in_byte[2:0]} + ZA_W'(1);

  always_comb begin
    if (!in_byte[7]) begin
      fit_run = {1'b0, in_byte[6:0]} + BYTE_W'(1);
    end else if (!in_byte[6]) begin
      fit_run = {2'b00, in_byte[5:0]} + BYTE_W'(1);
    end else begin
      fit_run = BYTE_W'(mix_lits) + BYTE_W'(mix_zeros);
    end
  end

  assign fit_sum = {1'b0, bytes_written} + (CNT_W+1)'(fit_run);
  assign fit_ok  = fit_sum <= {1'b0, capacity};

  always_comb begin
    expect_lit_next  = expect_lit;
    lit_left_next    = lit_left;
    zeros_after_next = zeros_after;
    err_code_next    = err_code;
    delta            = '0;
    plan_lit         = 1'b0;
    plan_zeros       = '0;
    if (err_code == STATUS_OK) begin
      if (expect_lit) begin
        plan_lit      = 1'b1;
        lit_left_next = lit_left - BYTE_W'(1);
        delta         = BYTE_W'(1);
        if (lit_left_next == '0) begin
          // run complete: flush the owed zeros
          plan_zeros       = ZC_W'(zeros_after);
          delta            = BYTE_W'(zeros_after) + BYTE_W'(1);
          expect_lit_next  = 1'b0;
          zeros_after_next = '0;
        end
      end else if (!fit_ok) begin
        err_code_next = STATUS_OVER;
      end else if (!in_byte[7]) begin
        lit_left_next    = fit_run;
        zeros_after_next = '0;
        expect_lit_next  = 1'b1;
      end else if (!in_byte[6]) begin
        plan_zeros = ZC_W'(fit_run);
        delta      = fit_run;
      end else begin
        lit_left_next    = BYTE_W'(mix_lits);
        zeros_after_next = mix_zeros;
        expect_lit_next  = 1'b1;
      end
    end
    bytes_written_next = bytes_written + CNT_W'(delta);

    plan_status = err_code_next;
    if (err_code_next == STATUS_OK && expect_lit_next) begin
      plan_status = STATUS_TRUNC;
    end
    plan_stat  = in_last && (plan_status != STATUS_OK || (!plan_lit && plan_zeros == '0));
    plan_total = (plan_status == STATUS_OK) ? bytes_written_next : '0;
    plan_any   = plan_lit || plan_zeros != '0 || plan_stat;
  end

  // pick the result to load and what remains behind it
  always_comb begin
    ld_byte      = '0;
    ld_has       = 1'b0;
    ld_rem_zeros = '0;
    ld_rem_stat  = 1'b0;
    if (cmd.accept) begin
      if (plan_lit) begin
        ld_byte      = in_byte;
        ld_has       = 1'b1;
        ld_rem_zeros = plan_zeros;
        ld_rem_stat  = plan_stat;
      end else if (plan_zeros != '0) begin
        ld_has       = 1'b1;
        ld_rem_zeros = plan_zeros - ZC_W'(1);
        ld_rem_stat  = plan_stat;
      end
    end else if (rem_zeros != '0) begin
      ld_has       = 1'b1;
      ld_rem_zeros = rem_zeros - ZC_W'(1);
      ld_rem_stat  = rem_stat;
    end
    ld_last   = ld_rem_zeros == '0 && !ld_rem_stat;
    ld_end    = ld_last && (cmd.accept ? in_last : end_flag);
    ld_status = ld_end ? (cmd.accept ? plan_status : end_status) : STATUS_OK;
    ld_total  = ld_end ? (cmd.accept ? plan_total : end_total) : '0;
  end

  assign load = (cmd.accept && plan_any) || cmd.advance;

  assign stat.out_valid = out_valid;
  assign stat.plan_more = plan_any && !ld_last;
  assign stat.rem_more  = !ld_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAP_RESET;
      expect_lit    <= 1'b0;
      lit_left      <= '0;
      zeros_after   <= '0;
      bytes_written <= '0;
      err_code      <= STATUS_OK;
      rem_zeros     <= '0;
      rem_stat      <= 1'b0;
      end_flag      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        capacity <= cfg_write_data;
      end
      if (cmd.accept) begin
        end_flag <= in_last;
        if (in_last) begin
          // stream done: clear for the next one
          expect_lit    <= 1'b0;
          lit_left      <= '0;
          zeros_after   <= '0;
          bytes_written <= '0;
          err_code      <= STATUS_OK;
        end else begin
          expect_lit    <= expect_lit_next;
          lit_left      <= lit_left_next;
          zeros_after   <= zeros_after_next;
          bytes_written <= bytes_written_next;
          err_code      <= err_code_next;
        end
      end
      if (load) begin
        rem_zeros <= ld_rem_zeros;
        rem_stat  <= ld_rem_stat;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      end_status <= plan_status;
      end_total  <= plan_total;
    end
    if (load) begin
      out_byte     <= ld_byte;
      has_byte     <= ld_has;
      run_last     <= ld_last;
      stream_end   <= ld_end;
      status       <= ld_status;
      total_length <= ld_total;
    end
  end

endmodule

[sv/zero_run_decompressor_core.sv]
`timescale 1ns / 1ps
// Zero-run decompressor top level: controller plus datapath.
// Depends on zrd_pkg, zrd_ctrl and zrd_datapath.
//
// Takes one compressed byte per item and gives decompressed bytes, one result
// per cycle while out_ready holds, from a single output register. Bytes that
// yield at most one result stream back to back while the output side is ready;
// a byte that yields n results (a zero run of up to 64 bytes,
// the zeros after a mixed run, or a trailing status result) holds off the
// next input while the output register drains them. The per-stream limit
// capacity is written through cfg_write_en / cfg_write_data and applies
// from the next opcode. After an overflow the rest of the stream is dropped,
// and the final result carries the status; its output must be discarded.
module zero_run_decompressor_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [zrd_pkg::CNT_W-1:0]     cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [zrd_pkg::BYTE_W-1:0]    in_byte,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [zrd_pkg::BYTE_W-1:0]    out_byte,
  output logic                          has_byte,
  output logic                          run_last,
  output logic                          stream_end,
  output logic [zrd_pkg::ST_W-1:0]      status,
  output logic [zrd_pkg::CNT_W-1:0]     total_length
);
  import zrd_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t stat;

  zrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  zrd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .has_byte       (has_byte),
    .run_last       (run_last),
    .stream_end     (stream_end),
    .status         (status),
    .total_length   (total_length)
  );

endmodule

[bench/zrd_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the zero-run decompressor: decodes each accepted input item
// itself and compares every accepted result against the oldest prediction.
// Depends on zrd_pkg for widths and status codes.
module zrd_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [zrd_pkg::CNT_W-1:0]  cfg_write_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [zrd_pkg::BYTE_W-1:0] in_byte,
  input  logic                       in_last,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [zrd_pkg::BYTE_W-1:0] out_byte,
  input  logic                       has_byte,
  input  logic                       run_last,
  input  logic                       stream_end,
  input  logic [zrd_pkg::ST_W-1:0]   status,
  input  logic [zrd_pkg::CNT_W-1:0]  total_length,
  output int                         mismatches,
  output int                         outstanding
);
  import zrd_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              has;
    logic              rlast;
    logic              send;
    logic [ST_W-1:0]   st;
    logic [CNT_W-1:0]  total;
  } dec_result_t;

  dec_result_t decoded_q[$];

  logic [CNT_W-1:0] capacity;
  logic             lit_mode;
  logic [7:0]       lit_left;
  logic [ZA_W-1:0]  zeros_owed;
  logic [CNT_W-1:0] produced;
  logic [ST_W-1:0]  fault;
  int               bad_count = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic void clear_stream();
    lit_mode   = 1'b0;
    lit_left   = '0;
    zeros_owed = '0;
    produced   = '0;
    fault      = STATUS_OK;
  endfunction

  function automatic bit fits_capacity(int unsigned run);
    return 32'(produced) + run <= 32'(capacity);
  endfunction

  function automatic dec_result_t data_out(logic [BYTE_W-1:0] v);
    dec_result_t r;
    r       = '0;
    r.data  = v;
    r.has   = 1'b1;
    return r;
  endfunction

  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic fin);
    dec_result_t burst[$];
    dec_result_t tail;
    logic [ST_W-1:0] st;
    int unsigned nl, nz;
    if (fault == STATUS_OK) begin
      if (lit_mode) begin
        burst.push_back(data_out(b));
        produced = produced + 1'b1;
        lit_left = lit_left - 1'b1;
        if (lit_left == 0) begin
          // literals done: flush the zeros a mixed run still owes
          repeat (zeros_owed) begin
            burst.push_back(data_out('0));
            produced = produced + 1'b1;
          end
          zeros_owed = '0;
          lit_mode   = 1'b0;
        end
      end else if (!b[7]) begin
        nl = int'(b[6:0]) + 1;
        if (fits_capacity(nl)) begin
          lit_left   = 8'(nl);
          zeros_owed = '0;
          lit_mode   = 1'b1;
        end else begin
          fault = STATUS_OVER;
        end
      end else if (!b[6]) begin
        nz = int'(b[5:0]) + 1;
        if (fits_capacity(nz)) begin
          repeat (nz) burst.push_back(data_out('0));
          produced = produced + CNT_W'(nz);
        end else begin
          fault = STATUS_OVER;
        end
      end else begin
        nl = int'(b[5:3]) + 1;
        nz = int'(b[2:0]) + 1;
        if (fits_capacity(nl + nz)) begin
          lit_left   = 8'(nl);
          zeros_owed = ZA_W'(nz);
          lit_mode   = 1'b1;
        end else begin
          fault = STATUS_OVER;
        end
      end
    end

    if (fin) begin
      st = fault;
      if (st == STATUS_OK && lit_mode) st = STATUS_TRUNC;
      if (st != STATUS_OK || burst.size() == 0) burst.push_back('0);
      tail       = burst.pop_back();
      tail.send  = 1'b1;
      tail.st    = st;
      tail.total = (st == STATUS_OK) ? produced : '0;
      burst.push_back(tail);
      clear_stream();
    end

    if (burst.size() > 0) begin
      tail       = burst.pop_back();
      tail.rlast = 1'b1;
      burst.push_back(tail);
    end
    foreach (burst[k]) decoded_q.push_back(burst[k]);
  endtask

  always @(posedge clk) begin
    dec_result_t want, got;
    if (rst) begin
      decoded_q.delete();
      clear_stream();
      capacity = CAP_RESET;
    end else begin
      if (cfg_write_en) capacity = cfg_write_data;
      if (in_valid && in_ready) decode_byte(in_byte, in_last);
      if (out_valid && out_ready) begin
        got.data  = out_byte;
        got.has   = has_byte;
        got.rlast = run_last;
        got.send  = stream_end;
        got.st    = status;
        got.total = total_length;
        if (decoded_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("zrd: unexpected result at %0t: byte=%h has=%b last=%b end=%b st=%0d len=%0d",
                     $realtime, got.data, got.has, got.rlast, got.send, got.st, got.total);
        end else begin
          want = decoded_q.pop_front();
          if (got != want) begin
            bad_count++;
            if (bad_count <= 10)
              $display({"zrd: mismatch at %0t: expected byte=%h has=%b last=%b end=%b st=%0d ",
                        "len=%0d, got byte=%h has=%b last=%b end=%b st=%0d len=%0d"},
                       $realtime, want.data, want.has, want.rlast, want.send, want.st,
                       want.total, got.data, got.has, got.rlast, got.send, got.st, got.total);
          end
        end
      end
    end
    mismatches  <= bad_count;
    outstanding <= decoded_q.size();
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Top of the zero-run decompressor bench: clock, reset, capacity settings and
// compressed streams with random gaps on both sides; gives the verdict.
// Depends on zrd_pkg, zero_run_decompressor_core and zrd_checker.
module tb;
  import zrd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 16;

  localparam logic       OP_LIT   = 1'b0;
  localparam logic [1:0] OP_ZEROS = 2'b10;
  localparam logic [1:0] OP_MIXED = 2'b11;

  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic              fin;
  } comp_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write_en = 1'b0;
  logic [CNT_W-1:0]  cfg_write_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              in_last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              has_byte;
  logic              run_last;
  logic              stream_end;
  logic [ST_W-1:0]   status;
  logic [CNT_W-1:0]  total_length;
  int                mismatches;
  int                outstanding;

  bit calm_in  = 1'b0;
  bit calm_out = 1'b0;
  bit hold_req = 1'b0;

  comp_item_t stream_q[$];

  always #5 clk = ~clk;

  zero_run_decompressor_core uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .has_byte       (has_byte),
    .run_last       (run_last),
    .stream_end     (stream_end),
    .status         (status),
    .total_length   (total_length)
  );

  zrd_checker chk (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .has_byte       (has_byte),
    .run_last       (run_last),
    .stream_end     (stream_end),
    .status         (status),
    .total_length   (total_length),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  function automatic void add_item(logic [BYTE_W-1:0] c);
    stream_q.push_back('{code: c, fin: 1'b0});
  endfunction

  function automatic void add_literals(int n);
    repeat (n) add_item(8'($urandom_range(0, 255)));
  endfunction

  function automatic void end_stream();
    comp_item_t tail;
    tail     = stream_q.pop_back();
    tail.fin = 1'b1;
    stream_q.push_back(tail);
  endfunction

  // Mostly well-formed streams with random content; some cut short, some noise.
  task automatic build_random_stream();
    int style, nops, len, cut, r;
    logic [BYTE_W-1:0] op;
    style = $urandom_range(0, 19);
    if (style < 2) begin
      add_literals($urandom_range(1, 8));
    end else begin
      nops = $urandom_range(1, 5);
      repeat (nops) begin
        case ($urandom_range(0, 2))
          0: begin
            r = $urandom_range(0, 99);
            if (r < 70) len = $urandom_range(1, 8);
            else if (r < 97) len = $urandom_range(9, 40);
            else len = 128;
            add_item({OP_LIT, 7'(len - 1)});
            add_literals(len);
          end
          1: add_item({OP_ZEROS, 6'($urandom_range(0, 63))});
          default: begin
            op = {OP_MIXED, 6'($urandom_range(0, 63))};
            add_item(op);
            add_literals(int'(op[5:3]) + 1);
          end
        endcase
      end
      if (style < 5 && stream_q.size() > 1) begin
        // cut the tail so the stream may end on a bare opcode or inside a run
        cut = $urandom_range(1, stream_q.size() - 1);
        repeat (cut) void'(stream_q.pop_back());
      end
    end
    end_stream();
  endtask

  task automatic send_item(input comp_item_t it);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= it.code;
    in_last  <= it.fin;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic run_stream();
    calm_in  = ($urandom_range(0, 4) == 0);
    calm_out = ($urandom_range(0, 4) == 0);
    foreach (stream_q[k]) send_item(stream_q[k]);
    stream_q.delete();
  endtask

  task automatic random_phase(int quota);
    int sent;
    sent = 0;
    while (sent < quota) begin
      build_random_stream();
      sent += stream_q.size();
      run_stream();
    end
  endtask

  // Drop valid, wait for every predicted result, then let the block go quiet.
  task automatic finish_phase();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // Receiver: random stall before each result, one long hold-off on request.
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = calm_out ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // a single-literal run, zero runs at both extremes, mixed runs at both extremes,
    // stream ending on the zeros of a mixed run
    add_item({OP_LIT, 7'd0});
    add_item(8'hFF);
    add_item({OP_ZEROS, 6'd0});
    add_item({OP_ZEROS, 6'd63});
    add_item({OP_MIXED, 3'd0, 3'd0});
    add_item(8'hAA);
    add_item({OP_MIXED, 3'd7, 3'd7});
    for (int k = 0; k < 8; k++) add_item(8'(1 << k));
    end_stream();
    run_stream();
    // trailing zero-run opcode is a complete stream
    add_item({OP_ZEROS, 6'd5});
    end_stream();
    run_stream();
    // bare literal opcode at the end: truncated
    add_item({OP_LIT, 7'd127});
    end_stream();
    run_stream();
    // literal run cut short
    add_item({OP_LIT, 7'd2});
    add_item(8'h11);
    add_item(8'h22);
    end_stream();
    run_stream();
    // mixed run cut short inside its literals
    add_item({OP_MIXED, 3'd1, 3'd0});
    add_item(8'h5A);
    end_stream();
    run_stream();
    finish_phase();

    write_capacity(CAP_RESET);
    hold_req = 1'b1;
    random_phase(70);
    finish_phase();

    // every opcode overflows
    write_capacity('0);
    random_phase(15);
    finish_phase();

    write_capacity(CNT_W'($urandom_range(10, 60)));
    random_phase(40);
    finish_phase();

    // a zero run that fills the capacity exactly, then an overflow
    write_capacity(CNT_W'(4));
    add_item({OP_ZEROS, 6'd3});
    add_item({OP_LIT, 7'd0});
    add_item(8'h55);
    end_stream();
    run_stream();
    random_phase(20);
    finish_phase();

    write_capacity(CNT_W'($urandom_range(100, 1000)));
    random_phase(45);
    finish_phase();

    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
sv/zrd_pkg.sv
sv/zrd_ctrl.sv
sv/zrd_datapath.sv
sv/zero_run_decompressor_core.sv
bench/zrd_checker.sv
bench/tb.sv
